[sv/cfe_pkg.sv]
// Shared types, constants and small helpers for the cuckoo filter engine.
// No dependencies; every other file of the block imports this package.
package cfe_pkg;

    // Default sizes, handed down as parameter defaults from the top level.
    localparam int DEF_MAX_BUCKETS   = 4096;
    localparam int DEF_SLOTS         = 4;
    localparam int DEF_MAX_KICKS     = 500;
    localparam int DEF_MAX_KEY_WORDS = 8;

    // Hash constants.
    localparam logic [63:0] MUL_M     = 64'hc6a4a7935bd1e995;
    localparam int          SHR_R     = 47;
    localparam logic [63:0] HSEED     = 64'h00000000adc83b19;
    // Starting accumulator for the two-byte fingerprint hash.
    localparam logic [63:0] FP_HSTART = HSEED ^ (MUL_M << 1);
    localparam int          FP_SHIFT  = 48;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Field widths fixed by the register map and the payload.
    localparam int CNT_W  = 13;
    localparam int LEN_W  = 7;
    localparam int SEED_W = 16;
    localparam int FP_W   = 16;

    // Register reset values.
    localparam logic [CNT_W-1:0]  RST_COUNT = 13'd4096;
    localparam logic [LEN_W-1:0]  RST_LEN   = 7'd32;
    localparam logic [SEED_W-1:0] RST_SEED  = 16'd44257;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_COUNT = 2'd0;
    localparam t_reg_idx REG_LEN   = 2'd1;
    localparam t_reg_idx REG_SEED  = 2'd2;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_PRESENT  = 2'd1,
        ST_FULL     = 2'd2,
        ST_ABSENT   = 2'd3
    } t_status;

    // Effective configuration and write pulses from the register file to the core.
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [LEN_W-1:0]  len;
        logic              restart;
        logic              seed_load;
        logic [SEED_W-1:0] seed;
    } t_cfg;

    function automatic logic [63:0] xshift(input logic [63:0] v);
        return v ^ (v >> SHR_R);
    endfunction

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        logic [15:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

[sv/cfe_mul.sv]
// Multiplier by the hash constant, low 64 bits of the product.
// One 32x32 multiplier takes the LL, LH and HL parts in turn; depends on cfe_pkg.
module cfe_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    output logic        o_done,
    output logic [63:0] o_p
);
    import cfe_pkg::*;

    localparam logic [31:0] M_LO    = MUL_M[31:0];
    localparam logic [31:0] M_HI    = MUL_M[63:32];
    localparam logic [1:0]  STEP_LL = 2'd0;
    localparam logic [1:0]  STEP_LH = 2'd1;
    localparam logic [1:0]  STEP_HL = 2'd2;

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_step;
    logic [63:0] r_a;
    logic [63:0] r_p;
    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] prod;

    always_comb begin
        unique case (r_step)
            STEP_LL: begin mx = r_a[31:0];  my = M_LO; end
            STEP_LH: begin mx = r_a[31:0];  my = M_HI; end
            default: begin mx = r_a[63:32]; my = M_LO; end
        endcase
    end

    assign prod = 64'(mx) * 64'(my);

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_LL;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_LL;
            r_a    <= i_a;
        end else if (r_busy) begin
            if (r_step == STEP_LL) begin
                r_p <= prod;
            end else begin
                r_p <= r_p + {prod[31:0], 32'd0};
            end
            if (r_step == STEP_HL) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
            r_step <= r_step + 2'd1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

endmodule

[sv/cfe_mod.sv]
// Iterative remainder of a 64-bit hash by the bucket count, four bits a cycle.
// Depends on cfe_pkg for the count width.
module cfe_mod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [63:0]               i_dividend,
    input  logic [cfe_pkg::CNT_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [cfe_pkg::CNT_W-1:0] o_rem
);
    import cfe_pkg::*;

    localparam int DIGITS = 4;
    localparam int STEPS  = 64 / DIGITS;
    localparam int SCW    = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [SCW-1:0]   r_cnt;
    logic [63:0]      r_q;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_div;
    logic [CNT_W-1:0] rem_n;

    always_comb begin
        logic [CNT_W:0] t;
        rem_n = r_rem;
        for (int b = 0; b < DIGITS; b++) begin
            t = {rem_n, r_q[63 - b]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            rem_n = t[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_q    <= i_dividend;
            r_div  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= rem_n;
            r_q   <= r_q << DIGITS;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == SCW'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[sv/cfe_core.sv]
// Sequencer of the cuckoo filter: key hashing, bucket store and eviction.
// Depends on cfe_pkg, cfe_mul and cfe_mod.
module cfe_core #(
    parameter int MAX_BUCKETS      = cfe_pkg::DEF_MAX_BUCKETS,
    parameter int SLOTS_PER_BUCKET = cfe_pkg::DEF_SLOTS,
    parameter int MAX_KICKS        = cfe_pkg::DEF_MAX_KICKS,
    parameter int MAX_KEY_WORDS    = cfe_pkg::DEF_MAX_KEY_WORDS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cfe_pkg::t_cfg            i_cfg,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_mode,
    input  logic [63:0]              i_key_word,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic [cfe_pkg::FP_W-1:0] o_fingerprint
);
    import cfe_pkg::*;

    localparam int IW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int AW  = ((IW > CNT_W) ? IW : CNT_W) + 1;
    localparam int BW  = SLOTS_PER_BUCKET * FP_W;
    localparam int SW  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int KW  = $clog2(MAX_KICKS + 1);
    localparam int WCW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
    localparam longint unsigned SLOT_RECIP =
        ((64'd1 << 32) + SLOTS_PER_BUCKET - 1) / SLOTS_PER_BUCKET;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_INIT, S_WORD, S_K1, S_K2, S_ACC, S_FIN, S_MOD,
        S_ALT0, S_ALT1, S_ALT2, S_RD1, S_RD2, S_DEC, S_KICK_RD, S_KICK_WR,
        S_KCHK_RD, S_KCHK, S_OUT
    } t_state;

    typedef enum logic {RET_I2, RET_KICK} t_ret;

    t_state           r_state;
    t_ret             r_ret;
    logic [IW-1:0]    r_clr_addr;
    logic [WCW-1:0]   r_word_cnt;
    logic             r_mode;
    logic [63:0]      r_word;
    logic [63:0]      r_acc;
    logic [15:0]      r_lfsr;
    logic [FP_W-1:0]  r_fp;
    logic [FP_W-1:0]  r_cur_fp;
    logic [FP_W-1:0]  r_alt_fp;
    logic [IW-1:0]    r_alt_idx;
    logic [IW-1:0]    r_i1;
    logic [IW-1:0]    r_i2;
    logic [IW-1:0]    r_cur;
    logic [SW-1:0]    r_slot;
    logic [KW-1:0]    r_kick;
    logic [BW-1:0]    r_b1;
    t_status          r_res;
    logic             r_out_valid;
    t_status          r_out_status;
    logic [FP_W-1:0]  r_out_fp;

    logic             r_mul_start;
    logic [63:0]      r_mul_a;
    logic             r_mod_start;
    logic [63:0]      r_mod_a;
    logic             mul_done;
    logic [63:0]      mul_p;
    logic             mod_done;
    logic [CNT_W-1:0] mod_rem;

    // Bucket store: one row per bucket, all slots side by side.
    logic [BW-1:0]    mem [MAX_BUCKETS];
    logic             r_we;
    logic [IW-1:0]    r_waddr;
    logic [BW-1:0]    r_wdata;
    logic [IW-1:0]    mem_raddr;
    logic [BW-1:0]    r_mem_q;

    cfe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    cfe_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mod_start),
        .i_dividend (r_mod_a),
        .i_divisor  (i_cfg.count),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    function automatic logic has_fp(input logic [BW-1:0] b, input logic [FP_W-1:0] fp);
        logic hit;
        hit = 1'b0;
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            if (b[s*FP_W +: FP_W] == fp) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic has_free(input logic [BW-1:0] b);
        logic f;
        f = 1'b0;
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            if (b[s*FP_W +: FP_W] == '0) begin
                f = 1'b1;
            end
        end
        return f;
    endfunction

    // Writes the fingerprint into the lowest empty slot.
    function automatic logic [BW-1:0] put_fp(input logic [BW-1:0] b,
                                             input logic [FP_W-1:0] fp);
        logic [BW-1:0] r;
        logic          done;
        r    = b;
        done = 1'b0;
        for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
            if (!done && b[s*FP_W +: FP_W] == '0) begin
                r[s*FP_W +: FP_W] = fp;
                done = 1'b1;
            end
        end
        return r;
    endfunction

    // Key length decode.
    logic [LEN_W-4:0] full_words;
    logic [2:0]       tail_bytes;
    int               nwords;
    logic             word_full;
    logic             last_word;
    logic [63:0]      tail_mask;

    assign full_words = i_cfg.len[LEN_W-1:3];
    assign tail_bytes = i_cfg.len[2:0];
    assign nwords     = int'(full_words) + ((tail_bytes != 3'd0) ? 1 : 0);
    assign word_full  = int'(r_word_cnt) < int'(full_words);
    assign last_word  = (int'(r_word_cnt) + 1) >= nwords;
    assign tail_mask  = (64'd1 << {tail_bytes, 3'b000}) - 64'd1;

    // Fingerprint of the finished hash, zero replaced by one.
    logic [63:0]     h_fin;
    logic [FP_W-1:0] fp_c;

    assign h_fin = xshift(mul_p);
    assign fp_c  = (h_fin[63:FP_SHIFT] == '0) ? FP_W'(1) : h_fin[63:FP_SHIFT];

    // Alternate index: shift by clz32(count) + 33, then one conditional subtract.
    logic [3:0]    cnt_bits;
    logic [6:0]    alt_sh;
    logic [63:0]   alt_part;
    logic [AW-1:0] alt_x;
    logic [IW-1:0] alt_c;

    always_comb begin
        cnt_bits = 4'd0;
        for (int i = 0; i < CNT_W; i++) begin
            if (i_cfg.count[i]) begin
                cnt_bits = 4'(i + 1);
            end
        end
        alt_sh   = 7'd65 - 7'(cnt_bits);
        alt_part = h_fin >> alt_sh;
        alt_x    = AW'(r_alt_idx) ^ alt_part[AW-1:0];
        if (alt_x >= AW'(i_cfg.count)) begin
            alt_x = alt_x - AW'(i_cfg.count);
        end
        alt_c = alt_x[IW-1:0];
    end

    // Victim generator and slot choice by reciprocal multiply.
    logic [15:0] lfsr_nxt;
    logic [48:0] slot_prod;
    logic [16:0] slot_q;
    logic [16:0] slot_r;
    logic [SW-1:0] slot_c;

    assign lfsr_nxt  = lfsr_step(r_lfsr);
    assign slot_prod = 49'(SLOT_RECIP) * 49'(lfsr_nxt);
    assign slot_q    = slot_prod[48:32];
    assign slot_r    = 17'(lfsr_nxt) - 17'(slot_q * 17'(SLOTS_PER_BUCKET));
    assign slot_c    = SW'(slot_r);

    // Row read for a kick with the incoming fingerprint in the victim slot.
    logic [BW-1:0] kick_row;
    always_comb begin
        kick_row = r_mem_q;
        kick_row[r_slot*FP_W +: FP_W] = r_cur_fp;
    end

    always_comb begin
        unique case (r_state)
            S_RD1:   mem_raddr = r_i1;
            S_RD2:   mem_raddr = r_i2;
            default: mem_raddr = r_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            mem[r_waddr] <= r_wdata;
        end
        r_mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        r_mul_start <= 1'b0;
        r_mod_start <= 1'b0;
        r_we        <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ret       <= RET_I2;
            r_clr_addr  <= '0;
            r_word_cnt  <= '0;
            r_mode      <= MODE_ADD;
            r_lfsr      <= RST_SEED;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_we       <= 1'b1;
                    r_waddr    <= r_clr_addr;
                    r_wdata    <= '0;
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == IW'(MAX_BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_word <= i_key_word;
                        if (r_word_cnt == '0) begin
                            r_mode      <= i_mode;
                            r_mul_a     <= 64'(i_cfg.len);
                            r_mul_start <= 1'b1;
                            r_state     <= S_INIT;
                        end else begin
                            r_state <= S_WORD;
                        end
                    end
                end
                S_INIT: begin
                    if (mul_done) begin
                        r_acc   <= HSEED ^ mul_p;
                        r_state <= S_WORD;
                    end
                end
                S_WORD: begin
                    r_mul_start <= 1'b1;
                    if (word_full) begin
                        r_mul_a <= r_word;
                        r_state <= S_K1;
                    end else begin
                        r_mul_a <= r_acc ^ (r_word & tail_mask);
                        r_state <= S_ACC;
                    end
                end
                S_K1: begin
                    if (mul_done) begin
                        r_mul_a     <= xshift(mul_p);
                        r_mul_start <= 1'b1;
                        r_state     <= S_K2;
                    end
                end
                S_K2: begin
                    if (mul_done) begin
                        r_mul_a     <= r_acc ^ mul_p;
                        r_mul_start <= 1'b1;
                        r_state     <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (mul_done) begin
                        r_acc <= mul_p;
                        if (last_word) begin
                            r_word_cnt  <= '0;
                            r_mul_a     <= xshift(mul_p);
                            r_mul_start <= 1'b1;
                            r_state     <= S_FIN;
                        end else begin
                            r_word_cnt <= r_word_cnt + 1'b1;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                S_FIN: begin
                    if (mul_done) begin
                        r_fp        <= fp_c;
                        r_mod_a     <= h_fin;
                        r_mod_start <= 1'b1;
                        r_state     <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_i1      <= IW'(mod_rem);
                        r_alt_idx <= IW'(mod_rem);
                        r_alt_fp  <= r_fp;
                        r_ret     <= RET_I2;
                        r_state   <= S_ALT0;
                    end
                end
                S_ALT0: begin
                    r_mul_a     <= FP_HSTART ^ 64'(r_alt_fp);
                    r_mul_start <= 1'b1;
                    r_state     <= S_ALT1;
                end
                S_ALT1: begin
                    if (mul_done) begin
                        r_mul_a     <= xshift(mul_p);
                        r_mul_start <= 1'b1;
                        r_state     <= S_ALT2;
                    end
                end
                S_ALT2: begin
                    if (mul_done) begin
                        unique case (r_ret)
                            RET_I2: begin
                                r_i2    <= alt_c;
                                r_state <= S_RD1;
                            end
                            RET_KICK: begin
                                r_cur   <= alt_c;
                                r_state <= S_KCHK_RD;
                            end
                        endcase
                    end
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_b1    <= r_mem_q;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    priority if (r_mode == MODE_CHECK) begin
                        r_res   <= (has_fp(r_b1, r_fp) || has_fp(r_mem_q, r_fp)) ?
                                   ST_PRESENT : ST_ABSENT;
                        r_state <= S_OUT;
                    end else if (has_fp(r_b1, r_fp) || has_fp(r_mem_q, r_fp)) begin
                        r_res   <= ST_PRESENT;
                        r_state <= S_OUT;
                    end else if (has_free(r_b1)) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_i1;
                        r_wdata <= put_fp(r_b1, r_fp);
                        r_res   <= ST_INSERTED;
                        r_state <= S_OUT;
                    end else if (has_free(r_mem_q)) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_i2;
                        r_wdata <= put_fp(r_mem_q, r_fp);
                        r_res   <= ST_INSERTED;
                        r_state <= S_OUT;
                    end else begin
                        r_lfsr   <= lfsr_nxt;
                        r_cur    <= lfsr_nxt[0] ? r_i1 : r_i2;
                        r_cur_fp <= r_fp;
                        r_kick   <= '0;
                        r_state  <= S_KICK_RD;
                    end
                end
                S_KICK_RD: begin
                    r_lfsr  <= lfsr_nxt;
                    r_slot  <= slot_c;
                    r_state <= S_KICK_WR;
                end
                S_KICK_WR: begin
                    r_we      <= 1'b1;
                    r_waddr   <= r_cur;
                    r_wdata   <= kick_row;
                    r_cur_fp  <= r_mem_q[r_slot*FP_W +: FP_W];
                    r_alt_fp  <= r_mem_q[r_slot*FP_W +: FP_W];
                    r_alt_idx <= r_cur;
                    r_ret     <= RET_KICK;
                    r_state   <= S_ALT0;
                end
                S_KCHK_RD: begin
                    r_state <= S_KCHK;
                end
                S_KCHK: begin
                    priority if (has_fp(r_mem_q, r_cur_fp)) begin
                        r_res   <= ST_PRESENT;
                        r_state <= S_OUT;
                    end else if (has_free(r_mem_q)) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_cur;
                        r_wdata <= put_fp(r_mem_q, r_cur_fp);
                        r_res   <= ST_INSERTED;
                        r_state <= S_OUT;
                    end else if (r_kick == KW'(MAX_KICKS - 1)) begin
                        r_res   <= ST_FULL;
                        r_state <= S_OUT;
                    end else begin
                        r_kick  <= r_kick + 1'b1;
                        r_state <= S_KICK_RD;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res;
                        r_out_fp     <= r_fp;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // The user must make register writes only while idle; not enforced here. They restart the key.
            if (i_cfg.restart) begin
                r_word_cnt <= '0;
            end
            if (i_cfg.seed_load) begin
                r_lfsr <= (i_cfg.seed == '0) ? 16'd1 : i_cfg.seed;
            end
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_fingerprint = r_out_fp;

endmodule

[sv/cuckoo_filter_engine.sv]
// Top level of the cuckoo filter engine: register file, port handshakes, core.
// Depends on cfe_pkg and cfe_core (which holds cfe_mul and cfe_mod).
//
// The engine hashes a key with MurmurHash64A, keeps 16-bit fingerprints in a
// bucket store of MAX_BUCKETS rows by SLOTS_PER_BUCKET slots, and answers one
// add or check per key. A key arrives as ceil(key_length / 8) input beats of 64
// bits each, little-endian; mode is taken from the first beat. One output beat
// follows the last input beat of every key, carrying status and fingerprint.
// After reset the engine sweeps the bucket store to zero, one row a cycle;
// during that sweep the input stays stalled, while register writes are taken
// as usual. Work is done one key at a time and is set by a single 32x32
// multiplier used three times per 64-bit product: a full key word is mixed
// and folded into the hash with it, the first word of a key also hashes the
// length, and the end of a key does the final mix, a remainder by the bucket
// count, the alternate index and two bucket reads. Eviction runs for up to
// MAX_KICKS steps. The input beat of the next key is taken while a finished
// result still waits in the output register.
// Registers (32-bit APB, byte addresses 0, 4, 8): bucket_count, key_length,
// lfsr_seed. A write to one of these starts the next key afresh; write only
// while the engine is idle.
module cuckoo_filter_engine #(
    parameter int MAX_BUCKETS      = cfe_pkg::DEF_MAX_BUCKETS,
    parameter int SLOTS_PER_BUCKET = cfe_pkg::DEF_SLOTS,
    parameter int MAX_KICKS        = cfe_pkg::DEF_MAX_KICKS,
    parameter int MAX_KEY_WORDS    = cfe_pkg::DEF_MAX_KEY_WORDS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cfe_pkg::ADDR_W-1:0] paddr,
    input  logic [cfe_pkg::DATA_W-1:0] pwdata,
    output logic [cfe_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    // Key word input
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_mode,
    input  logic [63:0]                i_key_word,
    // Result output
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic [cfe_pkg::FP_W-1:0]   o_fingerprint
);
    import cfe_pkg::*;

    // Clamp limits for the effective count and length.
    localparam logic [CNT_W-1:0] CNT_CAP =
        (MAX_BUCKETS >= (1 << CNT_W)) ? {CNT_W{1'b1}} : CNT_W'(MAX_BUCKETS);
    localparam logic [LEN_W-1:0] LEN_CAP =
        (MAX_KEY_WORDS * 8 >= (1 << LEN_W)) ? {LEN_W{1'b1}} : LEN_W'(MAX_KEY_WORDS * 8);

    logic [CNT_W-1:0]  r_count;
    logic [LEN_W-1:0]  r_len;
    logic [SEED_W-1:0] r_seed;
    logic              cfg_wr;
    t_reg_idx          cfg_idx;
    t_cfg              cfg;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= RST_COUNT;
            r_len   <= RST_LEN;
            r_seed  <= RST_SEED;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_COUNT: r_count <= pwdata[CNT_W-1:0];
                REG_LEN:   r_len   <= pwdata[LEN_W-1:0];
                REG_SEED:  r_seed  <= pwdata[SEED_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_COUNT: prdata = DATA_W'(r_count);
            REG_LEN:   prdata = DATA_W'(r_len);
            REG_SEED:  prdata = DATA_W'(r_seed);
            default:   prdata = '0;
        endcase
    end

    // Effective values seen by the core; a zero count or length acts as one.
    always_comb begin
        if (r_count == '0) begin
            cfg.count = CNT_W'(1);
        end else if (r_count > CNT_CAP) begin
            cfg.count = CNT_CAP;
        end else begin
            cfg.count = r_count;
        end
        if (r_len == '0) begin
            cfg.len = LEN_W'(1);
        end else if (r_len > LEN_CAP) begin
            cfg.len = LEN_CAP;
        end else begin
            cfg.len = r_len;
        end
        // Writes to unknown addresses change nothing, not even the key state.
        cfg.restart   = cfg_wr && (cfg_idx == REG_COUNT || cfg_idx == REG_LEN ||
                                   cfg_idx == REG_SEED);
        cfg.seed_load = cfg_wr && (cfg_idx == REG_SEED);
        cfg.seed      = pwdata[SEED_W-1:0];
    end

    cfe_core #(
        .MAX_BUCKETS      (MAX_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
        .MAX_KICKS        (MAX_KICKS),
        .MAX_KEY_WORDS    (MAX_KEY_WORDS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_key_word    (i_key_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_fingerprint (o_fingerprint)
    );

endmodule

[sv/cfe_checker.sv]
// Port-level checks for the cuckoo filter engine, bound to the top level.
// Depends on cfe_pkg for the fingerprint width.
module cfe_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [1:0]               o_status,
    input logic [cfe_pkg::FP_W-1:0] o_fingerprint
);
    import cfe_pkg::*;

    // The store sweep after reset keeps the input closed.
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input open right after reset");

    // A fingerprint of zero would read as an empty slot.
    a_fp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_fingerprint != '0)
        else $error("zero fingerprint on result beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_status) && $stable(o_fingerprint))
        else $error("result beat changed while stalled");

endmodule

bind cuckoo_filter_engine cfe_checker u_cfe_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for cuckoo_filter_engine: directed tests, then random keys.
// Depends on cfe_pkg and the engine RTL; it carries its own filter predictor.
module tb_top;
    import cfe_pkg::*;

    typedef struct packed {
        t_status     st;
        logic [15:0] fp;
    } t_answer;

    localparam int        NBUCKETS  = DEF_MAX_BUCKETS;
    localparam int        NSLOTS    = DEF_SLOTS;
    localparam int        NKICKS    = DEF_MAX_KICKS;
    localparam int        NWORDS    = DEF_MAX_KEY_WORDS;
    localparam t_reg_idx  REG_NONE  = 2'd3;
    localparam int        IDLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic        pready;
    logic        i_in_valid, o_in_stall, i_mode;
    logic [63:0] i_key_word;
    logic        o_out_valid, i_out_stall;
    logic [1:0]  o_status;
    logic [15:0] o_fingerprint;

    cuckoo_filter_engine i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_mode(i_mode), .i_key_word(i_key_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_fingerprint(o_fingerprint)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Filter predictor state: a private copy of the table, registers and hash.
    logic [15:0] tbl [NBUCKETS*NSLOTS];
    logic [12:0] cfg_count;
    logic [6:0]  cfg_len;
    logic [15:0] cfg_seed;
    logic [15:0] lfsr;
    logic [63:0] hacc;
    int          words_in;
    logic        key_mode;

    t_answer     answers_q[$];
    int          errors;
    int          snd_idle;
    int          rcv_idle;
    int          quiet_cycles;

    // Keys already sent, kept so that adds and checks can hit them again.
    logic [63:0] key_pool [$][NWORDS];

    function automatic logic [63:0] eff_count();
        if (cfg_count == 0) return 64'd1;
        if (cfg_count > NBUCKETS) return 64'(NBUCKETS);
        return 64'(cfg_count);
    endfunction

    function automatic int eff_len();
        if (cfg_len == 0) return 1;
        if (cfg_len > NWORDS*8) return NWORDS*8;
        return int'(cfg_len);
    endfunction

    function automatic int key_words();
        return (eff_len() + 7) / 8;
    endfunction

    function automatic logic [63:0] fmix(input logic [63:0] h);
        logic [63:0] v;
        v = h ^ (h >> 47);
        v = v * 64'hc6a4a7935bd1e995;
        return v ^ (v >> 47);
    endfunction

    function automatic void restart_hash();
        words_in = 0;
        hacc = 64'h00000000adc83b19 ^ (64'(eff_len()) * 64'hc6a4a7935bd1e995);
    endfunction

    function automatic logic [15:0] lfsr_advance();
        logic [15:0] v;
        v = {1'b0, lfsr[15:1]};
        if (lfsr[0]) begin
            v = v ^ 16'hB400;
        end
        lfsr = v;
        return v;
    endfunction

    function automatic int other_bucket(input int idx, input logic [15:0] fp,
                                        input logic [63:0] cnt);
        int          lead;
        int          sh;
        logic [63:0] h;
        logic [31:0] part;
        lead = 0;
        for (int b = 31; b >= 0 && cnt[b] == 1'b0; b--) lead++;
        sh = lead + 33;
        part = 32'd0;
        if (sh < 64) begin
            h = (64'h00000000adc83b19 ^ (64'd2 * 64'hc6a4a7935bd1e995)) ^ 64'(fp);
            h = h * 64'hc6a4a7935bd1e995;
            h = fmix(h);
            part = 32'(h >> sh);
        end
        return int'(64'(32'(idx) ^ part) % cnt);
    endfunction

    function automatic bit holds(input int b, input logic [15:0] fp);
        for (int s = 0; s < NSLOTS; s++) begin
            if (tbl[b*NSLOTS+s] == fp) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit place(input int b, input logic [15:0] fp);
        for (int s = 0; s < NSLOTS; s++) begin
            if (tbl[b*NSLOTS+s] == 16'd0) begin
                tbl[b*NSLOTS+s] = fp;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Add with cuckoo eviction: the victim moves to its other bucket until it
    // lands, duplicates there, or the kick budget is spent.
    function automatic t_status insert_fp(input logic [15:0] fp_in, input int b1,
                                          input int b2, input logic [63:0] cnt);
        logic [15:0] fp;
        logic [15:0] victim;
        int          cur;
        int          slot;
        fp = fp_in;
        if (holds(b1, fp) || holds(b2, fp)) return ST_PRESENT;
        if (place(b1, fp) || place(b2, fp)) return ST_INSERTED;
        cur = lfsr_advance() & 1 ? b1 : b2;
        for (int k = 0; k < NKICKS; k++) begin
            slot = lfsr_advance() % NSLOTS;
            victim = tbl[cur*NSLOTS+slot];
            tbl[cur*NSLOTS+slot] = fp;
            fp = victim;
            cur = other_bucket(cur, fp, cnt);
            if (holds(cur, fp)) return ST_PRESENT;
            if (place(cur, fp)) return ST_INSERTED;
        end
        return ST_FULL;
    endfunction

    // Folds one accepted beat into the hash; the last beat of a key yields an answer.
    function automatic void absorb_beat(input logic m, input logic [63:0] w);
        logic [63:0] k;
        logic [63:0] h;
        logic [63:0] cnt;
        logic [15:0] fp;
        int          b1, b2, rem;
        t_answer     a;
        rem = eff_len() % 8;
        if (words_in == 0) key_mode = m;
        if (words_in < eff_len() / 8) begin
            k = w * 64'hc6a4a7935bd1e995;
            k = k ^ (k >> 47);
            k = k * 64'hc6a4a7935bd1e995;
            hacc = (hacc ^ k) * 64'hc6a4a7935bd1e995;
        end else begin
            hacc = (hacc ^ (w & ((64'd1 << (rem*8)) - 64'd1))) * 64'hc6a4a7935bd1e995;
        end
        words_in++;
        if (words_in < key_words()) return;
        h = fmix(hacc);
        restart_hash();
        fp = h[63:48];
        if (fp == 0) fp = 16'd1;
        cnt = eff_count();
        b1 = int'(h % cnt);
        b2 = other_bucket(b1, fp, cnt);
        if (key_mode == MODE_CHECK) begin
            a.st = (holds(b1, fp) || holds(b2, fp)) ? ST_PRESENT : ST_ABSENT;
        end else begin
            a.st = insert_fp(fp, b1, b2, cnt);
        end
        a.fp = fp;
        answers_q.push_back(a);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Output side: random stall, checking of accepted beats, and the watchdog.
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answers_q.size() == 0) begin
                report_mismatch("unexpected result", o_fingerprint, 16'd0);
            end else begin
                a = answers_q.pop_front();
                if (o_status != a.st) begin
                    report_mismatch("status", 16'(o_status), 16'(a.st));
                end
                if (o_fingerprint != a.fp) report_mismatch("fingerprint", o_fingerprint, a.fp);
            end
        end
        if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("RESULT: ERROR");
            $finish;
        end
        i_out_stall <= ($urandom_range(99) < rcv_idle);
    end

    // APB write: setup cycle then access cycle; the predictor follows the write.
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_COUNT: cfg_count = value[12:0];
            REG_LEN:   cfg_len = value[6:0];
            REG_SEED: begin
                cfg_seed = value[15:0];
                lfsr = (cfg_seed == 0) ? 16'd1 : cfg_seed;
            end
            default: return;
        endcase
        restart_hash();
    endtask

    // Sends one beat; the valid stays high afterwards unless the next call idles.
    task automatic send_beat(input logic m, input logic [63:0] w);
        if ($urandom_range(99) < snd_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_key_word <= w;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        absorb_beat(m, w);
    endtask

    task automatic send_key(input logic m, input logic [63:0] words[NWORDS]);
        for (int i = 0; i < key_words(); i++) send_beat(m, words[i]);
        key_pool.push_back(words);
        if (key_pool.size() > 64) void'(key_pool.pop_front());
    endtask

    // Lowers valid and waits until every answer has come, plus a settling margin.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (answers_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(7))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_key(input logic m);
        logic [63:0] w[NWORDS];
        for (int i = 0; i < NWORDS; i++) w[i] = pick_word();
        send_key(m, w);
    endtask

    task automatic repeat_key(input logic m);
        if (key_pool.size() == 0) random_key(m);
        else send_key(m, key_pool[$urandom_range(key_pool.size()-1)]);
    endtask

    // Default registers: extreme words, a repeated add, found and absent checks.
    task automatic test_defaults();
        logic [63:0] zeros[NWORDS];
        logic [63:0] ones[NWORDS];
        for (int i = 0; i < NWORDS; i++) begin
            zeros[i] = 64'd0;
            ones[i]  = '1;
        end
        send_key(MODE_ADD, zeros);
        send_key(MODE_ADD, ones);
        send_key(MODE_ADD, ones);
        send_key(MODE_CHECK, zeros);
        random_key(MODE_CHECK);
        drain();
    endtask

    // Key lengths at and beyond both ends, with all-ones words so that bytes
    // past the length would show if they were not masked.
    task automatic test_lengths();
        int lens[7] = '{0, 1, 7, 9, 64, 127, 24};
        logic [63:0] ones[NWORDS];
        for (int i = 0; i < NWORDS; i++) ones[i] = '1;
        foreach (lens[i]) begin
            reg_write(REG_LEN, lens[i]);
            send_key(MODE_ADD, ones);
            send_key(MODE_CHECK, ones);
            drain();
        end
    endtask

    // A write while a key is half received abandons it; a write to an unused
    // index leaves the half key in place, so the next words continue it.
    task automatic test_restart();
        send_beat(MODE_CHECK, pick_word());
        drain();
        reg_write(REG_SEED, 32'h0000_1234);
        random_key(MODE_ADD);
        drain();
        send_beat(MODE_ADD, pick_word());
        drain();
        reg_write(REG_NONE, 32'hFFFF_FFFF);
        random_key(MODE_ADD);
        drain();
    endtask

    // One bucket, then two, fill at once so adds evict and run out of kicks; then an over-cap count.
    task automatic test_eviction();
        reg_write(REG_LEN, 8);
        reg_write(REG_SEED, 0);
        reg_write(REG_COUNT, 0);
        for (int i = 0; i < 7; i++) random_key(MODE_ADD);
        repeat_key(MODE_CHECK);
        drain();
        reg_write(REG_COUNT, 2);
        reg_write(REG_SEED, 32'h0000_FFFF);
        for (int i = 0; i < 10; i++) random_key(MODE_ADD);
        drain();
        reg_write(REG_COUNT, 32'h0000_1FFF);
        random_key(MODE_ADD);
        drain();
    endtask

    // Random keys under one idling profile, with new registers for the phase.
    task automatic test_random(input int s_pct, input int r_pct, input int beats);
        int sent;
        snd_idle = s_pct;
        rcv_idle = r_pct;
        reg_write(REG_COUNT, $urandom_range(32, NBUCKETS));
        reg_write(REG_LEN, $urandom_range(1, 40));
        reg_write(REG_SEED, $urandom_range(0, 65535));
        sent = 0;
        while (sent < beats) begin
            if ($urandom_range(1)) repeat_key($urandom_range(1));
            else random_key($urandom_range(1));
            sent += key_words();
            if ($urandom_range(49) == 0) drain();
        end
        drain();
    endtask

    initial begin
        errors       = 0;
        quiet_cycles = 0;
        snd_idle     = 23;
        rcv_idle     = 46;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_in_valid   = 1'b0;
        i_mode       = MODE_ADD;
        i_key_word   = '0;
        i_out_stall  = 1'b0;
        foreach (tbl[i]) tbl[i] = 16'd0;
        cfg_count = RST_COUNT;
        cfg_len   = RST_LEN;
        cfg_seed  = RST_SEED;
        lfsr      = RST_SEED;
        restart_hash();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_lengths();
        test_restart();
        test_eviction();
        test_random(23, 46, 500);
        test_random(46, 23, 500);
        test_random(0, 0, 500);

        if (errors == 0 && answers_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            if (answers_q.size() != 0) $display("%0d results never came", answers_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
